[sv/assert_macros.svh]
// assertion macros for the pattern matcher rtl
// included by files that carry concurrent checks, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[sv/fspm_pkg.sv]
// shared types and constants of the pattern matcher
// no dependencies
package fspm_pkg;

    localparam int FACT_W       = 64;
    localparam int IDX_W        = 6;
    localparam int SEL_W        = 3;
    localparam int SLOT_W       = 6;
    localparam int LEN_IN_W     = 4;
    localparam int ID_W         = 16;
    localparam int POS_W        = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int LIST_IW      = 4;
    localparam int CNT_W        = 5;
    localparam int S_DATA_W     = 80;
    localparam int M_DATA_W     = 48;

    typedef enum logic [1:0] {
        OP_PRED_MASK = 2'd0,
        OP_RULE_SLOT = 2'd1,
        OP_GLYPH     = 2'd2,
        OP_RULE_HDR  = 2'd3
    } op_t;

    localparam logic [SEL_W-1:0] SEL_ALL  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_ANY  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_NONE = 3'd2;

    typedef struct packed {
        logic              en;
        logic [SEL_W-1:0]  sel;
        logic [IDX_W-1:0]  idx;
        logic [FACT_W-1:0] data;
    } pred_wr_t;

endpackage

[sv/fspm_pred_eval.sv]
// predicate mask tables and parallel predicate evaluation
// depends on fspm_pkg
module fspm_pred_eval #(
    parameter int NUM_PREDICATES = 64
) (
    input  logic                              aclk,
    input  fspm_pkg::pred_wr_t                wr,
    input  logic [fspm_pkg::FACT_W-1:0]       facts,
    output logic [NUM_PREDICATES-1:0]         sig
);

    localparam int PW = (NUM_PREDICATES > 1) ? $clog2(NUM_PREDICATES) : 1;

    logic [fspm_pkg::FACT_W-1:0] all_reg  [NUM_PREDICATES];
    logic [fspm_pkg::FACT_W-1:0] any_reg  [NUM_PREDICATES];
    logic [fspm_pkg::FACT_W-1:0] none_reg [NUM_PREDICATES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            unique case (wr.sel)
                fspm_pkg::SEL_ALL:  all_reg[PW'(wr.idx)]  <= wr.data;
                fspm_pkg::SEL_ANY:  any_reg[PW'(wr.idx)]  <= wr.data;
                fspm_pkg::SEL_NONE: none_reg[PW'(wr.idx)] <= wr.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PREDICATES; p++) begin
            sig[p] = ((facts & all_reg[p]) == all_reg[p])
                  && ((any_reg[p] == '0) || ((facts & any_reg[p]) != '0))
                  && ((facts & none_reg[p]) == '0);
        end
    end

endmodule

[sv/fspm_result_scan.sv]
// result scanner: walks the hit vector of one glyph, drops duplicates,
// caps the count and drives the registered result channel; depends on fspm_pkg
module fspm_result_scan #(
    parameter int NUM_RULES = 16,
    parameter int LW        = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  logic [NUM_RULES-1:0]                  hits,
    input  logic [NUM_RULES-1:0][fspm_pkg::ID_W-1:0] ids,
    input  logic [NUM_RULES-1:0][LW-1:0]          lens,
    input  logic [fspm_pkg::POS_W-1:0]            end_pos,
    output logic                                  busy,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fspm_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                  m_tlast
);

    localparam int RW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int LIM = fspm_pkg::RESULT_LIMIT;

    logic                                   busy_reg, busy_next;
    logic [NUM_RULES-1:0]                   pend_reg, pend_next;
    logic [NUM_RULES-1:0][fspm_pkg::ID_W-1:0] id_reg, id_next;
    logic [NUM_RULES-1:0][LW-1:0]           len_reg, len_next;
    logic [fspm_pkg::POS_W-1:0]             end_reg, end_next;
    logic [LIM-1:0][fspm_pkg::ID_W-1:0]     lid_reg, lid_next;
    logic [LIM-1:0][LW-1:0]                 llen_reg, llen_next;
    logic [fspm_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic                                   held_valid_reg, held_valid_next;
    logic [fspm_pkg::ID_W-1:0]              held_id_reg, held_id_next;
    logic [LW-1:0]                          held_len_reg, held_len_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [fspm_pkg::M_DATA_W-1:0]          out_data_reg, out_data_next;
    logic                                   out_last_reg, out_last_next;

    logic                          found;
    logic [RW-1:0]                 first;
    logic [fspm_pkg::ID_W-1:0]     cand_id;
    logic [LW-1:0]                 cand_len;
    logic                          dup;
    logic                          out_free;
    logic [fspm_pkg::POS_W-1:0]    held_start;

    always_comb begin
        found = 1'b0;
        first = '0;
        for (int r = NUM_RULES - 1; r >= 0; r--) begin
            if (pend_reg[r]) begin
                found = 1'b1;
                first = RW'(r);
            end
        end
    end

    assign cand_id  = id_reg[first];
    assign cand_len = len_reg[first];
    assign out_free = !out_valid_reg || m_tready;
    assign held_start = end_reg - fspm_pkg::POS_W'(held_len_reg) + 16'd1;

    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < LIM; k++) begin
            if ((fspm_pkg::CNT_W'(k) < cnt_reg) && (lid_reg[k] == cand_id)
                    && (llen_reg[k] == cand_len)) begin
                dup = 1'b1;
            end
        end
    end

    always_comb begin
        busy_next       = busy_reg;
        pend_next       = pend_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        end_next        = end_reg;
        lid_next        = lid_reg;
        llen_next       = llen_reg;
        cnt_next        = cnt_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        held_len_next   = held_len_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        if (load) begin
            busy_next = 1'b1;
            pend_next = hits;
            id_next   = ids;
            len_next  = lens;
            end_next  = end_pos;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (found) begin
                if (dup) begin
                    pend_next[first] = 1'b0;
                end else if (!held_valid_reg || out_free) begin
                    if (held_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_data_next  = {end_reg, held_start, held_id_reg};
                        out_last_next  = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_id_next    = cand_id;
                    held_len_next   = cand_len;
                    lid_next[cnt_reg[fspm_pkg::LIST_IW-1:0]]  = cand_id;
                    llen_next[cnt_reg[fspm_pkg::LIST_IW-1:0]] = cand_len;
                    cnt_next = cnt_reg + 1'b1;
                    pend_next[first] = 1'b0;
                    if (cnt_next == fspm_pkg::CNT_W'(LIM)) begin
                        pend_next = '0;
                    end
                end
            end else if (held_valid_reg) begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = {end_reg, held_start, held_id_reg};
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    busy_next       = 1'b0;
                end
            end else begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            pend_reg       <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        len_reg      <= len_next;
        end_reg      <= end_next;
        lid_reg      <= lid_next;
        llen_reg     <= llen_next;
        held_id_reg  <= held_id_next;
        held_len_reg <= held_len_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign busy     = busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sv/fixed_slot_predicate_pattern_matcher_core.sv]
// top level of the fixed-slot predicate pattern matcher
// depends on fspm_pkg, fspm_pred_eval, fspm_result_scan and assert_macros.svh
//
//   channel   dir   tdata bits                                   side band
//   s_        in    opcode, table_index, word_select, value,     none
//                   rule_length, new_sequence (80 bits)
//   m_        out   rule_id, start_pos, end_pos (48 bits)        tlast = last
//
// one input word per cycle unless held; table writes finish on leaving the input register
// a glyph passes input register, signature register and rule match stage, then the
// scanner takes its hit rules one at a time and then closes the glyph's results
// glyphs without hits pass the match stage even while the scanner is busy
// reset clears rule lengths, match bits, position and all control; mask, slot and id
// tables hold their contents until written
// a stalled result channel holds the scanner, which holds the match stage and the input
`include "assert_macros.svh"

module fixed_slot_predicate_pattern_matcher_core #(
    parameter int NUM_PREDICATES = 64,
    parameter int NUM_RULES      = 16,
    parameter int MAX_RULE_LEN   = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode, table_index, word_select, value, rule_length, new_sequence
    input  logic [fspm_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rule_id, start_pos, end_pos
    output logic [fspm_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    localparam int RW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int SW = (MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1;
    localparam int LW = $clog2(MAX_RULE_LEN + 1);

    logic                           in_valid_reg;
    logic [fspm_pkg::S_DATA_W-1:0]  in_data_reg;
    logic                           in_exit;

    fspm_pkg::op_t                    op;
    logic [fspm_pkg::IDX_W-1:0]       idx;
    logic [fspm_pkg::SEL_W-1:0]       sel;
    logic [fspm_pkg::FACT_W-1:0]      value;
    logic [fspm_pkg::LEN_IN_W-1:0]    len_in;
    logic                             restart_in;

    fspm_pkg::pred_wr_t             pred_wr;
    logic [NUM_PREDICATES-1:0]      sig;

    logic                           sig_valid_reg;
    logic [NUM_PREDICATES-1:0]      sig_reg;
    logic                           restart_reg;
    logic                           sig_adv;

    logic [fspm_pkg::SLOT_W-1:0]    slots_reg [NUM_RULES][MAX_RULE_LEN];
    logic [NUM_RULES-1:0][fspm_pkg::ID_W-1:0] ids_reg;
    logic [NUM_RULES-1:0][LW-1:0]   lens_reg;
    logic [MAX_RULE_LEN-1:0]        pm_reg [NUM_RULES];
    logic [MAX_RULE_LEN-1:0]        pm_next [NUM_RULES];
    logic [fspm_pkg::POS_W-1:0]     pos_reg;
    logic [fspm_pkg::POS_W-1:0]     cur_pos;

    logic [fspm_pkg::FACT_W-1:0]    sig64;
    logic [NUM_RULES-1:0]           hits;
    logic                           any_hit;
    logic                           scan_busy;
    logic                           scan_load;
    logic                           hdr_wr;
    logic                           slot_wr;
    logic [LW-1:0]                  len_clamped;

    assign op         = fspm_pkg::op_t'(in_data_reg[1:0]);
    assign idx        = in_data_reg[7:2];
    assign sel        = in_data_reg[10:8];
    assign value      = in_data_reg[74:11];
    assign len_in     = in_data_reg[78:75];
    assign restart_in = in_data_reg[79];

    assign in_exit  = in_valid_reg && (!sig_valid_reg || sig_adv);
    assign s_tready = !in_valid_reg || in_exit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    always_comb begin
        pred_wr.en   = in_exit && (op == fspm_pkg::OP_PRED_MASK)
                    && (int'(idx) < NUM_PREDICATES)
                    && ((sel == fspm_pkg::SEL_ALL) || (sel == fspm_pkg::SEL_ANY)
                        || (sel == fspm_pkg::SEL_NONE));
        pred_wr.sel  = sel;
        pred_wr.idx  = idx;
        pred_wr.data = value;
    end

    fspm_pred_eval #(
        .NUM_PREDICATES (NUM_PREDICATES)
    ) u_pred_eval (
        .aclk  (aclk),
        .wr    (pred_wr),
        .facts (value),
        .sig   (sig)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_valid_reg <= 1'b0;
        end else if (in_exit && (op == fspm_pkg::OP_GLYPH)) begin
            sig_valid_reg <= 1'b1;
        end else if (sig_adv) begin
            sig_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_exit && (op == fspm_pkg::OP_GLYPH)) begin
            sig_reg     <= sig;
            restart_reg <= restart_in;
        end
    end

    assign hdr_wr  = in_exit && (op == fspm_pkg::OP_RULE_HDR) && (int'(idx) < NUM_RULES);
    assign slot_wr = in_exit && (op == fspm_pkg::OP_RULE_SLOT) && (int'(idx) < NUM_RULES)
                  && (int'(sel) < MAX_RULE_LEN);
    assign len_clamped = (int'(len_in) > MAX_RULE_LEN) ? LW'(MAX_RULE_LEN) : LW'(len_in);

    always_ff @(posedge aclk) begin
        if (slot_wr) begin
            slots_reg[RW'(idx)][SW'(sel)] <= value[fspm_pkg::SLOT_W-1:0];
        end
        if (hdr_wr) begin
            ids_reg[RW'(idx)] <= value[fspm_pkg::ID_W-1:0];
        end
    end

    // rule match stage
    assign sig64   = fspm_pkg::FACT_W'(sig_reg);
    assign cur_pos = restart_reg ? '0 : pos_reg;

    always_comb begin
        logic [MAX_RULE_LEN-1:0] base;
        logic [MAX_RULE_LEN-1:0] fire;
        logic [MAX_RULE_LEN-1:0] d;
        for (int r = 0; r < NUM_RULES; r++) begin
            base = restart_reg ? '0 : pm_reg[r];
            for (int s = 0; s < MAX_RULE_LEN; s++) begin
                fire[s] = sig64[slots_reg[r][s]] && (s < int'(lens_reg[r]));
            end
            d = ((base << 1) | MAX_RULE_LEN'(1)) & fire;
            pm_next[r] = d;
            hits[r] = 1'b0;
            for (int s = 0; s < MAX_RULE_LEN; s++) begin
                if (d[s] && (int'(lens_reg[r]) == s + 1)) begin
                    hits[r] = 1'b1;
                end
            end
        end
    end

    assign any_hit   = |hits;
    assign sig_adv   = sig_valid_reg && (!scan_busy || !any_hit);
    assign scan_load = sig_adv && any_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int r = 0; r < NUM_RULES; r++) begin
                lens_reg[r] <= '0;
                pm_reg[r]   <= '0;
            end
        end else begin
            if (sig_adv) begin
                pos_reg <= cur_pos + 16'd1;
            end
            for (int r = 0; r < NUM_RULES; r++) begin
                if (hdr_wr && (RW'(idx) == RW'(r))) begin
                    lens_reg[r] <= len_clamped;
                    pm_reg[r]   <= '0;
                end else if (sig_adv) begin
                    pm_reg[r] <= pm_next[r];
                end
            end
        end
    end

    fspm_result_scan #(
        .NUM_RULES (NUM_RULES),
        .LW        (LW)
    ) u_result_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (scan_load),
        .hits     (hits),
        .ids      (ids_reg),
        .lens     (lens_reg),
        .end_pos  (cur_pos),
        .busy     (scan_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_CLK(a_load_when_idle, aclk, aresetn, scan_load |-> !scan_busy)
    `ASSERT_CLK(a_stall_means_busy, aclk, aresetn, (sig_valid_reg && !sig_adv) |-> scan_busy)
    `ASSERT_NEVER(a_no_overrun, aclk, aresetn, in_valid_reg && !in_exit && s_tready)

endmodule

[verif/fspm_checker.sv]
// checker for the fixed-slot predicate pattern matcher: watches both channels,
// predicts the match words and compares them; depends on fspm_pkg
`timescale 1ns / 100ps

module fspm_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fspm_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fspm_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending_matches
);

    localparam int NPRED = 64;
    localparam int NRULE = 16;
    localparam int MAXLEN = 8;

    typedef struct packed {
        logic [15:0] rule_id;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic        last;
    } match_t;

    logic [63:0] all_tab [NPRED];
    logic [63:0] any_tab [NPRED];
    logic [63:0] none_tab [NPRED];
    logic [5:0]  slot_tab [NRULE*MAXLEN];
    logic [15:0] id_tab [NRULE];
    logic [3:0]  len_tab [NRULE];
    logic [7:0]  match_bits [NRULE];
    logic [15:0] position;
    match_t      match_q [$];

    assign pending_matches = match_q.size();

    task automatic apply_word(input logic [fspm_pkg::S_DATA_W-1:0] w);
        fspm_pkg::op_t op;
        logic [5:0]  idx;
        logic [2:0]  sel;
        logic [63:0] val;
        logic [3:0]  len;
        logic [63:0] sig;
        logic [7:0]  fire;
        logic [7:0]  d;
        logic [15:0] start;
        match_t      glyph_hits [$];
        match_t      m;
        logic        dup;
        op = fspm_pkg::op_t'(w[1:0]);
        idx = w[7:2];
        sel = w[10:8];
        val = w[74:11];
        len = w[78:75];
        case (op)
            fspm_pkg::OP_PRED_MASK: begin
                if (sel == fspm_pkg::SEL_ALL) all_tab[idx] = val;
                else if (sel == fspm_pkg::SEL_ANY) any_tab[idx] = val;
                else if (sel == fspm_pkg::SEL_NONE) none_tab[idx] = val;
            end
            fspm_pkg::OP_RULE_SLOT: begin
                if (idx < NRULE && sel < MAXLEN) slot_tab[idx*MAXLEN+sel] = val[5:0];
            end
            fspm_pkg::OP_RULE_HDR: begin
                if (idx < NRULE) begin
                    id_tab[idx] = val[15:0];
                    len_tab[idx] = (len > MAXLEN) ? 4'(MAXLEN) : len;
                    match_bits[idx] = '0;
                end
            end
            default: begin
                if (w[79]) begin
                    foreach (match_bits[r]) match_bits[r] = '0;
                    position = '0;
                end
                sig = '0;
                for (int p = 0; p < NPRED; p++)
                    if ((val & all_tab[p]) == all_tab[p]
                        && (any_tab[p] == 0 || (val & any_tab[p]) != 0)
                        && (val & none_tab[p]) == 0)
                        sig[p] = 1'b1;
                for (int r = 0; r < NRULE; r++) begin
                    if (len_tab[r] == 0) begin
                        match_bits[r] = '0;
                        continue;
                    end
                    fire = '0;
                    for (int s = 0; s < len_tab[r]; s++)
                        fire[s] = sig[slot_tab[r*MAXLEN+s]];
                    d = ((match_bits[r] << 1) | 8'd1) & fire;
                    match_bits[r] = d;
                    if (d[len_tab[r]-1]) begin
                        start = position - 16'(len_tab[r] - 1);
                        dup = 1'b0;
                        foreach (glyph_hits[k])
                            if (glyph_hits[k].rule_id == id_tab[r]
                                && glyph_hits[k].start_pos == start) dup = 1'b1;
                        if (!dup && glyph_hits.size() < fspm_pkg::RESULT_LIMIT) begin
                            m.rule_id = id_tab[r];
                            m.start_pos = start;
                            m.end_pos = position;
                            m.last = 1'b0;
                            glyph_hits = {glyph_hits, m};
                        end
                    end
                end
                if (glyph_hits.size() > 0) glyph_hits[glyph_hits.size()-1].last = 1'b1;
                match_q = {match_q, glyph_hits};
                position = position + 16'd1;
            end
        endcase
    endtask

    initial begin
        fail_count = 0;
        foreach (len_tab[r]) begin
            len_tab[r] = '0;
            match_bits[r] = '0;
        end
        position = '0;
    end

    always @(posedge aclk) begin
        match_t got;
        match_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) apply_word(s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast};
                if (match_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = match_q.pop_front();
                    if (got.rule_id != want.rule_id) begin
                        $display("%0t: rule_id expected %h actual %h", $time,
                                 want.rule_id, got.rule_id);
                        fail_count++;
                    end
                    if (got.start_pos != want.start_pos) begin
                        $display("%0t: start_pos expected %h actual %h", $time,
                                 want.start_pos, got.start_pos);
                        fail_count++;
                    end
                    if (got.end_pos != want.end_pos) begin
                        $display("%0t: end_pos expected %h actual %h", $time,
                                 want.end_pos, got.end_pos);
                        fail_count++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_top.sv]
// stimulus and verdict for the fixed-slot predicate pattern matcher
// depends on fspm_pkg, fspm_checker and the matcher core
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int USED_PREDS  = 4;
    localparam int USED_RULES  = 4;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [fspm_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [fspm_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tlast;
    int                            fail_count;
    int                            pending_matches;
    int                            cycle_count = 0;
    bit                            calm_phase = 1'b0;
    bit                            hold_sink = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fixed_slot_predicate_pattern_matcher_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    fspm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_matches(pending_matches)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off
    initial begin
        int n;
        @(posedge aclk);
        while (1) begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // leaves tvalid high after the accepting edge; wait_drained drops it
    task automatic send_word(input fspm_pkg::op_t op, input logic [5:0] idx,
                             input logic [2:0] sel, input logic [63:0] val,
                             input logic [3:0] len, input bit ns);
        int n;
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge aclk);
        end
        s_tdata <= {ns, len, val, sel, idx, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_matches != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // loading words that the block ignores, or that only rewrite slot entries of the used rules
    task automatic send_stray();
        case ($urandom_range(0, 3))
            0: send_word(fspm_pkg::OP_PRED_MASK, 6'($urandom_range(0, USED_PREDS - 1)),
                         3'($urandom_range(3, 7)), rand64(), 4'($urandom()), 1'($urandom()));
            1: send_word(fspm_pkg::OP_RULE_SLOT, 6'($urandom_range(16, 63)), 3'($urandom()),
                         rand64(), 4'($urandom()), 1'($urandom()));
            2: send_word(fspm_pkg::OP_RULE_HDR, 6'($urandom_range(16, 63)), 3'($urandom()),
                         rand64(), 4'($urandom()), 1'($urandom()));
            default: send_word(fspm_pkg::OP_RULE_SLOT, 6'($urandom_range(0, USED_RULES - 1)),
                               3'($urandom()), (rand64() & ~64'h3F)
                               | 64'($urandom_range(0, USED_PREDS - 1)),
                               4'($urandom()), 1'($urandom()));
        endcase
    endtask

    // a few predicates and rules; few facts bits make predicates fire often
    task automatic load_tables(input bit sparse);
        logic [63:0] m;
        int          len;
        for (int p = 0; p < USED_PREDS; p++) begin
            m = sparse ? (64'd1 << $urandom_range(0, 7)) : 64'd0;
            send_word(fspm_pkg::OP_PRED_MASK, 6'(p), fspm_pkg::SEL_ALL, m, 4'd0, 1'b0);
            m = sparse ? 64'($urandom_range(0, 255)) : 64'd0;
            send_word(fspm_pkg::OP_PRED_MASK, 6'(p), fspm_pkg::SEL_ANY, m, 4'd0, 1'b0);
            m = sparse ? (64'd1 << $urandom_range(8, 63)) : 64'd0;
            send_word(fspm_pkg::OP_PRED_MASK, 6'(p), fspm_pkg::SEL_NONE, m, 4'd0, 1'b0);
        end
        for (int r = 0; r < USED_RULES; r++) begin
            len = $urandom_range(0, 15);
            for (int s = 0; s < 8 && s < len; s++)
                send_word(fspm_pkg::OP_RULE_SLOT, 6'(r), 3'(s),
                          64'($urandom_range(0, USED_PREDS - 1)), 4'd0, 1'b0);
            send_word(fspm_pkg::OP_RULE_HDR, 6'(r), 3'd0,
                      (rand64() & ~64'hFFFF) | 64'($urandom_range(0, 3)), 4'(len), 1'b0);
        end
    endtask

    initial begin
        logic [63:0] f;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all-zero masks make the four used predicates fire
        for (int p = 0; p < USED_PREDS; p++) begin
            send_word(fspm_pkg::OP_PRED_MASK, 6'(p), fspm_pkg::SEL_ALL, 64'd0, 4'd0, 1'b0);
            send_word(fspm_pkg::OP_PRED_MASK, 6'(p), fspm_pkg::SEL_ANY, 64'd0, 4'd0, 1'b0);
            send_word(fspm_pkg::OP_PRED_MASK, 6'(p), fspm_pkg::SEL_NONE, 64'd0, 4'd0, 1'b0);
        end
        // duplicate ids and starts
        for (int r = 0; r < 4; r++) begin
            send_word(fspm_pkg::OP_RULE_SLOT, 6'(r), 3'd0, 64'd0, 4'd0, 1'b0);
            send_word(fspm_pkg::OP_RULE_SLOT, 6'(r), 3'd1, 64'd1, 4'd0, 1'b1);
            send_word(fspm_pkg::OP_RULE_HDR, 6'(r), 3'd0, 64'hFFFF_0000_0000_0007, 4'd2, 1'b0);
        end
        // over-long rule and a disabled one
        for (int s = 0; s < 8; s++)
            send_word(fspm_pkg::OP_RULE_SLOT, 6'd4, 3'(s), 64'(s % 4), 4'd0, 1'b0);
        send_word(fspm_pkg::OP_RULE_HDR, 6'd4, 3'd0, 64'h1234, 4'd15, 1'b1);
        send_word(fspm_pkg::OP_RULE_HDR, 6'd5, 3'd0, 64'h1234, 4'd0, 1'b0);
        send_word(fspm_pkg::OP_RULE_HDR, 6'd63, 3'd0, 64'h55, 4'd3, 1'b0);
        send_word(fspm_pkg::OP_RULE_SLOT, 6'd40, 3'd2, 64'd5, 4'd0, 1'b1);
        send_word(fspm_pkg::OP_PRED_MASK, 6'd3, 3'd5, '1, 4'd0, 1'b0);
        send_word(fspm_pkg::OP_PRED_MASK, 6'd3, 3'd7, '1, 4'd0, 1'b0);
        send_word(fspm_pkg::OP_GLYPH, 6'd0, 3'd0, 64'd0, 4'd0, 1'b1);
        for (int g = 0; g < 9; g++)
            send_word(fspm_pkg::OP_GLYPH, 6'd63, 3'd7, g[0] ? '1 : 64'd0, 4'd15, 1'b0);
        send_word(fspm_pkg::OP_RULE_HDR, 6'd0, 3'd0, 64'h9, 4'd1, 1'b0);
        send_word(fspm_pkg::OP_GLYPH, 6'd0, 3'd0, rand64(), 4'd0, 1'b1);
        wait_drained();

        // long receiver hold-off while the sender keeps offering glyphs
        hold_sink = 1'b1;
        for (int g = 0; g < 12; g++)
            send_word(fspm_pkg::OP_GLYPH, 6'd0, 3'd0, rand64(), 4'd0, 1'b0);
        wait_drained();

        // random: reload sparse tables, glyph streams with random content
        for (int phase = 0; phase < 2; phase++) begin
            load_tables(1'b1);
            if (phase == 1) calm_phase = 1'b1;
            for (int g = 0; g < 20; g++) begin
                f = rand64();
                if ($urandom_range(0, 3) != 0) f = f & 64'hFF | (rand64() & rand64() & rand64());
                if ($urandom_range(0, 9) == 0)
                    send_stray();
                else
                    send_word(fspm_pkg::OP_GLYPH, 6'($urandom()), 3'($urandom()), f,
                              4'($urandom()), $urandom_range(0, 15) == 0);
            end
            wait_drained();
        end

        while (pending_matches != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/fspm_pkg.sv
sv/fspm_pred_eval.sv
sv/fspm_result_scan.sv
sv/fixed_slot_predicate_pattern_matcher_core.sv
verif/fspm_checker.sv
verif/tb_top.sv
